### rtl/core/ialu_pkg.sv
`default_nettype none
package ialu_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIV_STAGES = 16;

  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_MUL = 4'd3;
  localparam logic [3:0] OP_DIV = 4'd4;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_OR  = 4'd6;
  localparam logic [3:0] OP_NOT = 4'd7;
  localparam logic [3:0] OP_XOR = 4'd8;
  localparam logic [3:0] OP_REM = 4'd9;
  localparam logic [3:0] OP_INC = 4'd10;
  localparam logic [3:0] OP_DEC = 4'd11;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_BADOP = 2'd2;

  // Payload that travels beside the divider.
  typedef struct packed {
    logic [3:0]        cmd;
    logic [DATA_W-1:0] res;
    logic [1:0]        status;
    logic              q_neg;
    logic              r_neg;
  } side_t;

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] dvs;
  } div_stage_t;

endpackage
`default_nettype wire

### rtl/core/integer_alu_with_divide.sv
`default_nettype none
// 32-bit integer ALU: add, sub, mul, div, and, or, not, xor, rem, inc, dec on
// signed operands, wrapping modulo 2^32. One item is accepted every cycle
// unless the output stalls, and every item passes through the pipelined
// restoring divider, which retires 32 / DIV_STAGES quotient bits per stage.
// All operations share the one pipeline, so results leave in order. A stall
// at the output holds the whole pipeline.
module integer_alu_with_divide #(
  parameter int unsigned DIV_STAGES = ialu_pkg::DIV_STAGES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // cmd[3:0], operand_a[35:4], operand_b[67:36], zeros
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // result[31:0], status[33:32], zeros
);

  localparam int unsigned W = ialu_pkg::DATA_W;

  logic          en;
  logic          a_valid_r;
  logic [3:0]    cmd_r;
  logic [W-1:0]  opa_r, opb_r;
  logic [DIV_STAGES:0] valid_r;
  ialu_pkg::side_t side_r [DIV_STAGES+1];
  ialu_pkg::side_t side_nxt;
  logic [W-1:0]  mag_a, mag_b, quo, rem;
  logic [W-1:0]  prod;
  logic [W-1:0]  res_r, res_nxt;
  logic [1:0]    status_r;
  logic          out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= in_tvalid;
      valid_r     <= {valid_r[DIV_STAGES-1:0], a_valid_r};
      out_valid_r <= valid_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r     <= in_tdata[3:0];
      opa_r     <= in_tdata[35:4];
      opb_r     <= in_tdata[67:36];
      side_r[0] <= side_nxt;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
      res_r    <= res_nxt;
      status_r <= side_r[DIV_STAGES].status;
    end
  end

  assign mag_a = opa_r[W-1] ? W'(-opa_r) : opa_r;
  assign mag_b = opb_r[W-1] ? W'(-opb_r) : opb_r;
  // Only the low half of the product is kept, so a W by W multiply suffices.
  assign prod  = opa_r * opb_r;

  always_comb begin
    side_nxt.cmd    = cmd_r;
    side_nxt.res    = '0;
    side_nxt.status = ialu_pkg::ST_OK;
    side_nxt.q_neg  = opa_r[W-1] ^ opb_r[W-1];
    side_nxt.r_neg  = opa_r[W-1];
    unique case (cmd_r) inside
      ialu_pkg::OP_ADD: side_nxt.res = opa_r + opb_r;
      ialu_pkg::OP_SUB: side_nxt.res = opa_r - opb_r;
      ialu_pkg::OP_MUL: side_nxt.res = prod;
      ialu_pkg::OP_AND: side_nxt.res = opa_r & opb_r;
      ialu_pkg::OP_OR:  side_nxt.res = opa_r | opb_r;
      ialu_pkg::OP_NOT: side_nxt.res = ~opa_r;
      ialu_pkg::OP_XOR: side_nxt.res = opa_r ^ opb_r;
      ialu_pkg::OP_INC: side_nxt.res = opa_r + W'(1);
      ialu_pkg::OP_DEC: side_nxt.res = opa_r - W'(1);
      ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
        if (opb_r == '0) side_nxt.status = ialu_pkg::ST_DIV0;
      end
      default: side_nxt.status = ialu_pkg::ST_BADOP;
    endcase
  end

  ialu_div_pipe #(.STAGES(DIV_STAGES)) u_div (
    .clk       (clk),
    .en        (en),
    .dividend  (mag_a),
    .divisor   (mag_b),
    .quotient  (quo),
    .remainder (rem)
  );

  // Signs are put back on the magnitudes once the divider is done.
  always_comb begin
    res_nxt = side_r[DIV_STAGES].res;
    if (side_r[DIV_STAGES].status == ialu_pkg::ST_OK) begin
      if (side_r[DIV_STAGES].cmd == ialu_pkg::OP_DIV) begin
        res_nxt = side_r[DIV_STAGES].q_neg ? W'(-quo) : quo;
      end else if (side_r[DIV_STAGES].cmd == ialu_pkg::OP_REM) begin
        res_nxt = side_r[DIV_STAGES].r_neg ? W'(-rem) : rem;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, status_r, res_r};

endmodule
`default_nettype wire

### rtl/core/ialu_div_pipe.sv
`default_nettype none
module ialu_div_pipe #(
  parameter int unsigned STAGES = ialu_pkg::DIV_STAGES
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [ialu_pkg::DATA_W-1:0] dividend,
  input  wire logic [ialu_pkg::DATA_W-1:0] divisor,
  output logic      [ialu_pkg::DATA_W-1:0] quotient,
  output logic      [ialu_pkg::DATA_W-1:0] remainder
);

  localparam int unsigned W   = ialu_pkg::DATA_W;
  localparam int unsigned BPS = W / STAGES;

  ialu_pkg::div_stage_t stg_r [STAGES+1];

  // Restoring division, W / STAGES quotient bits per stage.
  function automatic ialu_pkg::div_stage_t step(input ialu_pkg::div_stage_t s);
    ialu_pkg::div_stage_t o;
    logic [W:0] t;
    o = s;
    for (int i = 0; i < BPS; i++) begin
      t     = {o.rem, o.quo[W-1]};
      o.quo = {o.quo[W-2:0], 1'b0};
      if (t >= {1'b0, o.dvs}) begin
        t        = t - {1'b0, o.dvs};
        o.quo[0] = 1'b1;
      end
      o.rem = t[W-1:0];
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0].rem <= '0;
      stg_r[0].quo <= dividend;
      stg_r[0].dvs <= divisor;
      for (int k = 1; k <= STAGES; k++) begin
        stg_r[k] <= step(stg_r[k-1]);
      end
    end
  end

  assign quotient  = stg_r[STAGES].quo;
  assign remainder = stg_r[STAGES].rem;

endmodule
`default_nettype wire

### rtl/core/ialu_checker.sv
`default_nettype none
module ialu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] != 2'd3)
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] != 2'd0 |-> out_tdata[31:0] == 32'd0)
    else $error("non-zero result with error status");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind integer_alu_with_divide ialu_checker u_ialu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
